// ===== rtl/wmf_pkg.sv =====
// Shared types and constants for the 3x3 window max filter.
package wmf_pkg;

	localparam int CFG_W = 11;
	localparam logic [CFG_W-1:0] SIDE_RESET = 11'd1024;

	typedef struct packed {
		logic emit;
		logic row_end;
		logic frame_end;
	} wmf_flags_t;

endpackage

// ===== rtl/wmf_ram.sv =====
// Generic simple dual-port RAM with registered read.
module wmf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/wmf_pos.sv =====
// Side register, row and column tracking, and result flags for each accepted beat.
module wmf_pos #(
	parameter int MAX_SIDE = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [wmf_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        accept,
	input  logic                        frame_start,
	output logic [$clog2(MAX_SIDE)-1:0] col,
	output logic [$clog2(MAX_SIDE)-1:0] row,
	output wmf_pkg::wmf_flags_t         flags
);

	localparam int COL_W  = $clog2(MAX_SIDE);
	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int CMP_W  = (wmf_pkg::CFG_W > SIDE_W) ? wmf_pkg::CFG_W : SIDE_W;

	logic [wmf_pkg::CFG_W-1:0] side_q;
	logic [COL_W-1:0]          col_q;
	logic [COL_W-1:0]          row_q;
	logic [CMP_W-1:0]          side_ext;
	logic [CMP_W-1:0]          side_sat;
	logic [COL_W-1:0]          last;

	always_comb begin
		side_ext = CMP_W'(side_q);
		if (side_ext < CMP_W'(3)) begin
			side_sat = CMP_W'(3);
		end else if (side_ext > CMP_W'(MAX_SIDE)) begin
			side_sat = CMP_W'(MAX_SIDE);
		end else begin
			side_sat = side_ext;
		end
		last = COL_W'(side_sat - CMP_W'(1));
	end

	assign col = frame_start ? '0 : col_q;
	assign row = frame_start ? '0 : row_q;

	always_comb begin
		flags.emit      = (row >= COL_W'(2)) && (col >= COL_W'(2)) &&
		                  (row <= last) && (col <= last);
		flags.row_end   = flags.emit && (col == last);
		flags.frame_end = flags.row_end && (row == last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= wmf_pkg::SIDE_RESET;
			col_q  <= '0;
			row_q  <= '0;
		end else begin
			if (cfg_we) begin
				side_q <= cfg_wdata;
			end
			if (accept) begin
				if (col >= last) begin
					col_q <= '0;
					row_q <= (row >= last) ? '0 : row + COL_W'(1);
				end else begin
					col_q <= col + COL_W'(1);
					row_q <= row;
				end
			end
		end
	end

endmodule

// ===== rtl/wmf_window.sv =====
// Two held window columns and the nine-way max over the full window.
module wmf_window #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift,
	input  logic [PIXEL_BITS-1:0] top,
	input  logic [PIXEL_BITS-1:0] mid,
	input  logic [PIXEL_BITS-1:0] pix,
	output logic [PIXEL_BITS-1:0] win_max
);

	logic [PIXEL_BITS-1:0] old_q  [3];
	logic [PIXEL_BITS-1:0] prev_q [3];
	logic [PIXEL_BITS-1:0] m_a, m_b, m_c, m_d;

	function automatic logic [PIXEL_BITS-1:0] larger(
		input logic [PIXEL_BITS-1:0] a,
		input logic [PIXEL_BITS-1:0] b
	);
		return (a > b) ? a : b;
	endfunction

	always_comb begin
		m_a     = larger(larger(top, mid), pix);
		m_b     = larger(larger(old_q[0], old_q[1]), old_q[2]);
		m_c     = larger(larger(prev_q[0], prev_q[1]), prev_q[2]);
		m_d     = larger(m_b, m_c);
		win_max = larger(m_a, m_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				old_q[i]  <= '0;
				prev_q[i] <= '0;
			end
		end else if (shift) begin
			old_q[0]  <= prev_q[0];
			old_q[1]  <= prev_q[1];
			old_q[2]  <= prev_q[2];
			prev_q[0] <= top;
			prev_q[1] <= mid;
			prev_q[2] <= pix;
		end
	end

endmodule

// ===== rtl/window_max_filter_3x3_top.sv =====
// Pipeline: a window's last input beat is held in the s1 registers, its result in max_q.
// Throughput: one pixel beat per cycle while the output is not stalled; the line store
// RAM reads at accept, writes from the s1 stage, and a same-address collision bypasses it.
// Border pixels give no result beat; the output stalls hold the whole pipe in place.
// Reset: arst_n clears positions, window columns and valid flags, and sets the side to 1024.
// Line store contents are not cleared; no clearing pass is run.
module window_max_filter_3x3_top #(
	parameter int MAX_SIDE   = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wmf_pkg::CFG_W-1:0]           cfg_wdata, // image_side
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((PIXEL_BITS+7)/8)*8-1:0]     s_tdata,   // pixel_value
	input  logic                                s_tuser,   // frame_start
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((PIXEL_BITS+7)/8)*8-1:0]     m_tdata,   // window_max
	output logic                                m_tlast,   // row_end
	output logic                                m_tuser    // frame_end
);

	localparam int DATA_W = ((PIXEL_BITS + 7) / 8) * 8;
	localparam int COL_W  = $clog2(MAX_SIDE);
	localparam int PB     = PIXEL_BITS;

	logic                      advance;
	logic                      accept;
	logic [COL_W-1:0]          col;
	logic [COL_W-1:0]          row;
	wmf_pkg::wmf_flags_t       flags;

	logic                      s1_valid;
	wmf_pkg::wmf_flags_t       flags_s1;
	logic [COL_W-1:0]          col_s1;
	logic [COL_W-1:0]          row_s1;
	logic [PB-1:0]             pix_s1;
	logic                      byp_s1;
	logic [PB-1:0]             byp_top_s1;
	logic [PB-1:0]             byp_mid_s1;

	logic [2*PB-1:0]           rd_data;
	logic [2*PB-1:0]           wr_data;
	logic                      wr_en;
	logic [PB-1:0]             top_eff;
	logic [PB-1:0]             mid_eff;
	logic [PB-1:0]             win_max;

	logic                      out_valid_q;
	logic [PB-1:0]             max_q;
	logic                      row_end_q;
	logic                      frame_end_q;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = advance;
	assign accept   = s_tvalid && advance;
	assign wr_en    = s1_valid && advance;

	wmf_pos #(
		.MAX_SIDE (MAX_SIDE)
	) u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.accept      (accept),
		.frame_start (s_tuser),
		.col         (col),
		.row         (row),
		.flags       (flags)
	);

	assign top_eff = byp_s1 ? byp_top_s1 : rd_data[PB-1:0];
	assign mid_eff = byp_s1 ? byp_mid_s1 : rd_data[2*PB-1:PB];
	assign wr_data = {pix_s1, mid_eff};

	wmf_ram #(
		.WIDTH (2 * PB),
		.DEPTH (MAX_SIDE)
	) u_line_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (col_s1),
		.wdata (wr_data),
		.re    (accept),
		.raddr (col),
		.rdata (rd_data)
	);

	wmf_window #(
		.PIXEL_BITS (PB)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (wr_en),
		.top     (top_eff),
		.mid     (mid_eff),
		.pix     (pix_s1),
		.win_max (win_max)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			byp_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			s1_valid    <= s_tvalid;
			byp_s1      <= s_tvalid && s1_valid && (col == col_s1);
			out_valid_q <= s1_valid && flags_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1   <= flags;
			col_s1     <= col;
			row_s1     <= row;
			pix_s1     <= s_tdata[PB-1:0];
			byp_top_s1 <= mid_eff;
			byp_mid_s1 <= pix_s1;
		end
		if (wr_en) begin
			max_q       <= win_max;
			row_end_q   <= flags_s1.row_end;
			frame_end_q <= flags_s1.frame_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = DATA_W'(max_q);
	assign m_tlast  = row_end_q;
	assign m_tuser  = frame_end_q;

	a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tuser || m_tlast))
		else $error("frame_end without row_end");

	a_bypass_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		byp_s1 |-> s1_valid)
		else $error("forwarding flagged with empty stage");

	a_frame_start_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser) |=> (s1_valid && col_s1 == '0 && row_s1 == '0))
		else $error("frame start did not restart position");

	a_write_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !wr_en)
		else $error("line store written while output stalled");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the 3x3 window max filter: predicted window maxima vs. output beats.
module tb;

	localparam int MAX_SIDE     = 1024;
	localparam int PIXEL_BITS   = 8;
	localparam int DRAIN_CYCLES = 8;
	localparam int END_LIMIT    = 20000;
	localparam int LONG_HOLD    = 300;

	typedef struct packed {
		logic [7:0] window_max;
		logic       row_end;
		logic       frame_end;
	} window_beat_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_we    = 1'b0;
	logic [wmf_pkg::CFG_W-1:0]  cfg_wdata = '0;
	logic                       s_tvalid  = 1'b0;
	logic                       s_tready;
	logic [7:0]                 s_tdata   = '0; // pixel_value
	logic                       s_tuser   = 1'b0; // frame_start
	logic                       m_tvalid;
	logic                       m_tready  = 1'b0;
	logic [7:0]                 m_tdata; // window_max
	logic                       m_tlast; // row_end
	logic                       m_tuser; // frame_end

	logic [7:0]                 line_upper [MAX_SIDE];
	logic [7:0]                 line_middle [MAX_SIDE];
	logic [7:0]                 win_cols [6];
	int unsigned                col_pos;
	int unsigned                row_pos;
	logic [wmf_pkg::CFG_W-1:0]  side_reg = wmf_pkg::SIDE_RESET;

	window_beat_t               window_max_q [$];
	int                         mismatch_cnt = 0;
	int                         accepted_cnt = 0;
	int                         src_idle_pct = 0;
	int                         snk_idle_pct = 0;
	int                         hold_reqs = 0;
	int                         holds_done = 0;
	int                         hold_cnt = 0;

	window_max_filter_3x3_top #(
		.MAX_SIDE   (MAX_SIDE),
		.PIXEL_BITS (PIXEL_BITS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic int unsigned active_side();
		if (side_reg < 3) return 3;
		if (side_reg > MAX_SIDE) return MAX_SIDE;
		return side_reg;
	endfunction

	function automatic void dilate_pixel(input logic [7:0] pix, input logic fs);
		int unsigned n;
		int unsigned c;
		int unsigned r;
		int k;
		logic [7:0] top;
		logic [7:0] mid;
		logic [7:0] peak;
		window_beat_t beat;
		n = active_side();
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		c = col_pos;
		r = row_pos;
		top = line_upper[c];
		mid = line_middle[c];
		if (r >= 2 && c >= 2 && r <= n - 1 && c <= n - 1) begin
			peak = pix;
			if (top > peak) peak = top;
			if (mid > peak) peak = mid;
			for (k = 0; k < 6; k++)
				if (win_cols[k] > peak) peak = win_cols[k];
			beat.window_max = peak;
			beat.row_end    = (c == n - 1);
			beat.frame_end  = (c == n - 1) && (r == n - 1);
			window_max_q.push_back(beat);
		end
		line_upper[c]  = mid;
		line_middle[c] = pix;
		win_cols[0] = win_cols[3];
		win_cols[1] = win_cols[4];
		win_cols[2] = win_cols[5];
		win_cols[3] = top;
		win_cols[4] = mid;
		win_cols[5] = pix;
		if (c >= n - 1) begin
			col_pos = 0;
			row_pos = (r >= n - 1) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	function automatic logic [7:0] rand_pixel();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return $urandom_range(255);
		endcase
	endfunction

	task automatic push_pixel(input logic [7:0] pix, input logic fs);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom_range(255);
			s_tuser  <= $urandom_range(1);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		s_tuser  <= fs;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		accepted_cnt++;
		dilate_pixel(pix, fs);
	endtask

	task automatic push_run(input int count, input logic first_fs);
		int i;
		for (i = 0; i < count; i++)
			push_pixel(rand_pixel(), (i == 0) ? first_fs : 1'b0);
	endtask

	task automatic drain_results();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (window_max_q.size() != 0 && waited < END_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_side(input logic [wmf_pkg::CFG_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		side_reg = value;
	endtask

	// Border beats at the reset side, then shrink the side mid-frame and fill both line stores.
	task automatic test_full_side_rows();
		push_run(40, 1'b1);
		write_side(14);
		push_run(200, 1'b0);
	endtask

	task automatic test_side_saturation();
		write_side(0);
		push_run(8, 1'b1);
		write_side(11'd2047);
		push_run(3, 1'b0);
		write_side(11'd1025);
		push_run(1, 1'b0);
		write_side(2);
		push_run(9, 1'b0);
	endtask

	task automatic test_small_frame_cases();
		int i;
		write_side(3);
		for (i = 0; i < 9; i++)
			push_pixel(8'h00, i == 0);
		for (i = 0; i < 9; i++)
			push_pixel((i == 0) ? 8'hFF : 8'h00, 1'b0);
		push_run(4, 1'b1);
		for (i = 0; i < 9; i++)
			push_pixel((i == 4) ? 8'h7F : 8'h80, i == 0);
	endtask

	task automatic test_output_stall();
		write_side(10);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_reqs <= hold_reqs + 1;
		push_run(200, 1'b1);
		drain_results();
	endtask

	task automatic test_random_frames(input int items, input int src_pct, input int snk_pct);
		int start;
		int n;
		logic aligned;
		start = accepted_cnt;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		while (accepted_cnt - start < items) begin
			n = active_side();
			aligned = (col_pos == 0) && (row_pos == 0);
			case ($urandom_range(9))
				6: write_side($urandom_range(14));
				7: push_run($urandom_range(1, n * n - 1), 1'b1);
				8: begin
					push_run($urandom_range(1, n * n - 1), 1'b1);
					write_side($urandom_range(3, 14));
					push_run($urandom_range(1, 30), 1'b0);
				end
				9: repeat ($urandom_range(1, 6))
					push_pixel(rand_pixel(), $urandom_range(3) == 0);
				default: push_run(n * n, aligned ? ($urandom_range(2) != 0) : 1'b1);
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			hold_cnt   <= 0;
			holds_done <= 0;
		end else if (hold_reqs != holds_done) begin
			holds_done <= holds_done + 1;
			hold_cnt   <= LONG_HOLD;
			m_tready   <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin : check_beat
		window_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (window_max_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected beat: max=%0d row_end=%0b frame_end=%0b",
						m_tdata, m_tlast, m_tuser);
			end else begin
				want = window_max_q.pop_front();
				if (m_tdata !== want.window_max || m_tlast !== want.row_end ||
						m_tuser !== want.frame_end) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
							want.window_max, want.row_end, want.frame_end,
							m_tdata, m_tlast, m_tuser);
				end
			end
		end
	end

	initial begin
		int i;
		for (i = 0; i < MAX_SIDE; i++) begin
			line_upper[i]  = '0;
			line_middle[i] = '0;
		end
		for (i = 0; i < 6; i++)
			win_cols[i] = '0;
		col_pos = 0;
		row_pos = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_full_side_rows();
		test_side_saturation();
		test_small_frame_cases();
		test_output_stall();
		test_random_frames(200, 37, 88);
		test_random_frames(200, 88, 37);
		test_random_frames(200, 0, 0);
		drain_results();
		mismatch_cnt += window_max_q.size();
		if (mismatch_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
